// File: rtl/core/ecef_ltt_pkg.sv
// Shared types and constants of the ECEF / local tangent plane transform.
// Used by every module of the block; depends on nothing.
package ecef_ltt_pkg;

  // Default widths and fraction bits
  localparam int unsigned COORD_WIDTH_DEF    = 32;
  localparam int unsigned TRIG_FRAC_BITS_DEF = 30;

  // Configuration registers are all this wide
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 3;

  // Request codes carried in tuser of the input stream
  typedef enum logic [2:0] {
    REQ_ENU_FROM_ECEF_PT  = 3'd0,
    REQ_NED_FROM_ECEF_PT  = 3'd1,
    REQ_ENU_FROM_ECEF_VEC = 3'd2,
    REQ_NED_FROM_ECEF_VEC = 3'd3,
    REQ_ECEF_FROM_ENU_PT  = 3'd4,
    REQ_ECEF_FROM_ENU_VEC = 3'd5,
    REQ_ECEF_FROM_NED_PT  = 3'd6,
    REQ_ECEF_FROM_NED_VEC = 3'd7
  } req_type_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIN_LAT  = 3'd0,
    CFG_COS_LAT  = 3'd1,
    CFG_SIN_LON  = 3'd2,
    CFG_COS_LON  = 3'd3,
    CFG_ORIGIN_X = 3'd4,
    CFG_ORIGIN_Y = 3'd5,
    CFG_ORIGIN_Z = 3'd6
  } cfg_reg_e;

  // Decoded request flags that travel with an item
  typedef struct packed {
    logic inv;    // local frame to ECEF (transposed matrix)
    logic point;  // apply the origin
    logic ned;    // NED instead of ENU
  } req_ctl_t;

endpackage

// File: rtl/core/ecef_ltt_matrix.sv
// Configuration registers and the registered rotation matrix built from them.
// Depends on ecef_ltt_pkg.
module ecef_ltt_matrix #(
  parameter int unsigned TRIG_FRAC_BITS = ecef_ltt_pkg::TRIG_FRAC_BITS_DEF,
  localparam int unsigned MW = 64 - TRIG_FRAC_BITS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [ecef_ltt_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ecef_ltt_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output logic [8:0][MW-1:0]                     mat_o,
  output logic [2:0][ecef_ltt_pkg::CFG_DATA_W-1:0] org_o
);

  localparam int unsigned DW = ecef_ltt_pkg::CFG_DATA_W;
  localparam logic [DW-1:0] TRIG_ONE = DW'(1) << TRIG_FRAC_BITS;

  logic [DW-1:0] sin_lat_q, cos_lat_q, sin_lon_q, cos_lon_q;
  logic [2:0][DW-1:0] org_q;
  logic [8:0][MW-1:0] mat_q, mat_d;

  // Product of two trig values, rounded half up back to the fraction bits
  function automatic logic [MW-1:0] trig_mul(input logic signed [DW:0] a,
                                             input logic signed [DW:0] b);
    logic signed [2*DW+1:0] p;
    p = a * b;
    p = p + ((2*DW+2)'(1) <<< (TRIG_FRAC_BITS - 1));
    p = p >>> TRIG_FRAC_BITS;
    return p[MW-1:0];
  endfunction

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sin_lat_q <= '0;
      cos_lat_q <= TRIG_ONE;
      sin_lon_q <= '0;
      cos_lon_q <= TRIG_ONE;
      org_q     <= '0;
    end else if (cfg_we_i) begin
      case (ecef_ltt_pkg::cfg_reg_e'(cfg_idx_i))
        ecef_ltt_pkg::CFG_SIN_LAT:  sin_lat_q <= cfg_wdata_i;
        ecef_ltt_pkg::CFG_COS_LAT:  cos_lat_q <= cfg_wdata_i;
        ecef_ltt_pkg::CFG_SIN_LON:  sin_lon_q <= cfg_wdata_i;
        ecef_ltt_pkg::CFG_COS_LON:  cos_lon_q <= cfg_wdata_i;
        ecef_ltt_pkg::CFG_ORIGIN_X: org_q[0]  <= cfg_wdata_i;
        ecef_ltt_pkg::CFG_ORIGIN_Y: org_q[1]  <= cfg_wdata_i;
        ecef_ltt_pkg::CFG_ORIGIN_Z: org_q[2]  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Build the matrix; rows are east, north, up
  always_comb begin
    logic signed [DW:0] sl, cl, so, co, nsl, nso;
    sl  = $signed({sin_lat_q[DW-1], sin_lat_q});
    cl  = $signed({cos_lat_q[DW-1], cos_lat_q});
    so  = $signed({sin_lon_q[DW-1], sin_lon_q});
    co  = $signed({cos_lon_q[DW-1], cos_lon_q});
    nsl = -sl;
    nso = -so;
    mat_d[0] = MW'(nso);
    mat_d[1] = MW'(co);
    mat_d[2] = '0;
    mat_d[3] = trig_mul(nsl, co);
    mat_d[4] = trig_mul(nsl, so);
    mat_d[5] = MW'(cl);
    mat_d[6] = trig_mul(cl, co);
    mat_d[7] = trig_mul(cl, so);
    mat_d[8] = MW'(sl);
  end

  // Hold the matrix in registers to cut the multiplier path
  always_ff @(posedge clk_i) begin
    mat_q <= mat_d;
  end

  assign mat_o = mat_q;
  assign org_o = org_q;

endmodule

// File: rtl/core/ecef_ltt_rotate.sv
// Three pipeline stages: decode and origin subtract, nine products, row sums.
// Depends on ecef_ltt_pkg.
module ecef_ltt_rotate #(
  parameter int unsigned COORD_WIDTH    = ecef_ltt_pkg::COORD_WIDTH_DEF,
  parameter int unsigned TRIG_FRAC_BITS = ecef_ltt_pkg::TRIG_FRAC_BITS_DEF,
  localparam int unsigned MW = 64 - TRIG_FRAC_BITS,
  localparam int unsigned VW = ((COORD_WIDTH > 32) ? COORD_WIDTH : 32) + 1,
  localparam int unsigned PW = MW + VW,
  localparam int unsigned AW = PW + 2
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic [2:0]                               in_type_i,
  input  logic [2:0][COORD_WIDTH-1:0]              in_vec_i,
  input  logic [8:0][MW-1:0]                       mat_i,
  input  logic [2:0][ecef_ltt_pkg::CFG_DATA_W-1:0] org_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic [2:0][AW-1:0]                       out_acc_o,
  output logic                                     out_neg_o
);

  localparam int unsigned DW = ecef_ltt_pkg::CFG_DATA_W;

  logic en1, en2, en3;
  logic v1_q, v2_q, v3_q;
  ecef_ltt_pkg::req_ctl_t ctl_d, ctl1_q, ctl2_q;
  logic signed [VW-1:0] vec_d [3];
  logic signed [VW-1:0] vec1_q [3];
  logic signed [PW-1:0] prod_d [3][3];
  logic signed [PW-1:0] prod2_q [3][3];
  logic signed [AW-1:0] org_d [3];
  logic signed [AW-1:0] org2_q [3];
  logic signed [AW-1:0] acc_d [3];
  logic [2:0][AW-1:0] acc3_q;
  logic neg3_q;

  // Each stage moves when it is empty or the next one moves
  assign en3 = !v3_q || out_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Decode the request type
  always_comb begin
    ctl_d = '0;
    case (ecef_ltt_pkg::req_type_e'(in_type_i))
      ecef_ltt_pkg::REQ_ENU_FROM_ECEF_PT:  ctl_d = '{inv: 1'b0, point: 1'b1, ned: 1'b0};
      ecef_ltt_pkg::REQ_NED_FROM_ECEF_PT:  ctl_d = '{inv: 1'b0, point: 1'b1, ned: 1'b1};
      ecef_ltt_pkg::REQ_ENU_FROM_ECEF_VEC: ctl_d = '{inv: 1'b0, point: 1'b0, ned: 1'b0};
      ecef_ltt_pkg::REQ_NED_FROM_ECEF_VEC: ctl_d = '{inv: 1'b0, point: 1'b0, ned: 1'b1};
      ecef_ltt_pkg::REQ_ECEF_FROM_ENU_PT:  ctl_d = '{inv: 1'b1, point: 1'b1, ned: 1'b0};
      ecef_ltt_pkg::REQ_ECEF_FROM_ENU_VEC: ctl_d = '{inv: 1'b1, point: 1'b0, ned: 1'b0};
      ecef_ltt_pkg::REQ_ECEF_FROM_NED_PT:  ctl_d = '{inv: 1'b1, point: 1'b1, ned: 1'b1};
      ecef_ltt_pkg::REQ_ECEF_FROM_NED_VEC: ctl_d = '{inv: 1'b1, point: 1'b0, ned: 1'b1};
      default: ctl_d = '0;
    endcase
  end

  // Stage 1: subtract origin for forward points, reorder inverse NED input
  always_comb begin
    logic signed [VW-1:0] xe [3];
    logic signed [VW-1:0] oe [3];
    for (int j = 0; j < 3; j++) begin
      xe[j] = $signed({{(VW-COORD_WIDTH){in_vec_i[j][COORD_WIDTH-1]}}, in_vec_i[j]});
      oe[j] = $signed({{(VW-DW){org_i[j][DW-1]}}, org_i[j]});
    end
    for (int j = 0; j < 3; j++) begin
      vec_d[j] = xe[j];
    end
    if (!ctl_d.inv && ctl_d.point) begin
      for (int j = 0; j < 3; j++) begin
        vec_d[j] = xe[j] - oe[j];
      end
    end else if (ctl_d.inv && ctl_d.ned) begin
      vec_d[0] = xe[1];
      vec_d[1] = xe[0];
      vec_d[2] = -xe[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      ctl1_q <= ctl_d;
      for (int j = 0; j < 3; j++) vec1_q[j] <= vec_d[j];
    end
  end

  // Stage 2: one product per matrix element, transposed for inverse requests; shifted origin for inverse points
  always_comb begin
    logic signed [MW-1:0] el;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        el = ctl1_q.inv ? $signed(mat_i[3*j+i]) : $signed(mat_i[3*i+j]);
        prod_d[i][j] = el * vec1_q[j];
      end
      org_d[i] = (ctl1_q.inv && ctl1_q.point)
               ? ($signed({{(AW-DW){org_i[i][DW-1]}}, org_i[i]}) <<< TRIG_FRAC_BITS)
               : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      ctl2_q <= ctl1_q;
      for (int i = 0; i < 3; i++) begin
        org2_q[i] <= org_d[i];
        for (int j = 0; j < 3; j++) prod2_q[i][j] <= prod_d[i][j];
      end
    end
  end

  // Stage 3: add each row, swap east and north for forward NED
  always_comb begin
    logic signed [AW-1:0] s [3];
    for (int i = 0; i < 3; i++) begin
      s[i] = prod2_q[i][0] + prod2_q[i][1] + prod2_q[i][2] + org2_q[i];
    end
    acc_d[0] = s[0];
    acc_d[1] = s[1];
    acc_d[2] = s[2];
    if (!ctl2_q.inv && ctl2_q.ned) begin
      acc_d[0] = s[1];
      acc_d[1] = s[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      neg3_q <= !ctl2_q.inv && ctl2_q.ned;
      for (int i = 0; i < 3; i++) acc3_q[i] <= acc_d[i];
    end
  end

  assign out_valid_o = v3_q;
  assign out_acc_o   = acc3_q;
  assign out_neg_o   = neg3_q;

endmodule

// File: rtl/core/ecef_ltt_finish.sv
// Output stage: NED down negation, round half up, saturate, output register.
// Depends on ecef_ltt_pkg.
module ecef_ltt_finish #(
  parameter int unsigned COORD_WIDTH    = ecef_ltt_pkg::COORD_WIDTH_DEF,
  parameter int unsigned TRIG_FRAC_BITS = ecef_ltt_pkg::TRIG_FRAC_BITS_DEF,
  localparam int unsigned MW = 64 - TRIG_FRAC_BITS,
  localparam int unsigned VW = ((COORD_WIDTH > 32) ? COORD_WIDTH : 32) + 1,
  localparam int unsigned AW = MW + VW + 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0][AW-1:0]          in_acc_i,
  input  logic                        in_neg_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0][COORD_WIDTH-1:0] out_vec_o,
  output logic                        out_sat_o
);

  localparam logic [AW:0] HALF    = (AW+1)'(1) << (TRIG_FRAC_BITS - 1);
  localparam logic [AW:0] NEG_ADD = HALF + (AW+1)'(1);
  localparam logic [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic en;
  logic valid_q;
  logic [2:0][COORD_WIDTH-1:0] vec_d, vec_q;
  logic sat_d, sat_q;

  assign en = !valid_q || out_ready_i;
  assign in_ready_o = en;

  // Round and clip each coordinate; negate the down axis on the way
  always_comb begin
    logic [AW:0] a, t, r;
    logic hi_ones, hi_zeros;
    sat_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      a = {in_acc_i[i][AW-1], in_acc_i[i]};
      if (in_neg_i && i == 2) t = ~a + NEG_ADD;
      else                    t = a + HALF;
      r = $signed(t) >>> TRIG_FRAC_BITS;
      hi_ones  = &r[AW:COORD_WIDTH-1];
      hi_zeros = ~|r[AW:COORD_WIDTH-1];
      if (hi_ones || hi_zeros) begin
        vec_d[i] = r[COORD_WIDTH-1:0];
      end else begin
        vec_d[i] = r[AW] ? CMIN : CMAX;
        sat_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vec_q <= vec_d;
      sat_q <= sat_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_vec_o   = vec_q;
  assign out_sat_o   = sat_q;

endmodule

// File: rtl/core/ecef_local_tangent_transform_unit.sv
// Top level of the ECEF / local tangent plane (ENU, NED) rotation block.
// Depends on ecef_ltt_pkg, ecef_ltt_matrix, ecef_ltt_rotate, ecef_ltt_finish.
//
//   channel   direction  signals                       contents
//   s_axis    in         tvalid tready tdata tuser     in_x,in_y,in_z / req_type
//   m_axis    out        tvalid tready tdata tuser     out_x,out_y,out_z / saturated
//   cfg       in         cfg_we_i cfg_idx_i cfg_wdata_i  seven 32-bit registers
//
// One transaction can enter every cycle while the output is not stalled; its result
// passes four register stages (decode/subtract, products, row sums, round/saturate).
// A configuration write lands in the trig registers; the matrix register is rebuilt from them.
// Reset clears the valid bits and loads cos 1.0, sin 0 and a zero origin.
// Each stage advances when it is empty or the next one advances, so a stalled
// output holds its result while bubbles further up still fill.
module ecef_local_tangent_transform_unit #(
  parameter int unsigned COORD_WIDTH    = ecef_ltt_pkg::COORD_WIDTH_DEF,
  parameter int unsigned TRIG_FRAC_BITS = ecef_ltt_pkg::TRIG_FRAC_BITS_DEF,
  localparam int unsigned TDW = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [TDW-1:0]                        s_axis_tdata,  // in_x, in_y, in_z
  input  logic [2:0]                            s_axis_tuser,  // req_type
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [TDW-1:0]                        m_axis_tdata,  // out_x, out_y, out_z
  output logic                                  m_axis_tuser,  // saturated
  input  logic                                  cfg_we_i,
  input  logic [ecef_ltt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ecef_ltt_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int unsigned MW = 64 - TRIG_FRAC_BITS;
  localparam int unsigned VW = ((COORD_WIDTH > 32) ? COORD_WIDTH : 32) + 1;
  localparam int unsigned AW = MW + VW + 2;
  localparam int unsigned DW = ecef_ltt_pkg::CFG_DATA_W;

  logic [8:0][MW-1:0] mat;
  logic [2:0][DW-1:0] org;
  logic [2:0][COORD_WIDTH-1:0] in_vec, out_vec;
  logic [2:0][AW-1:0] acc;
  logic acc_valid, acc_ready, acc_neg;

  // Unpack input coordinates
  assign in_vec = s_axis_tdata[3*COORD_WIDTH-1:0];

  ecef_ltt_matrix #(
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_matrix (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .mat_o      (mat),
    .org_o      (org)
  );

  ecef_ltt_rotate #(
    .COORD_WIDTH   (COORD_WIDTH),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_rotate (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_type_i  (s_axis_tuser),
    .in_vec_i   (in_vec),
    .mat_i      (mat),
    .org_i      (org),
    .out_valid_o(acc_valid),
    .out_ready_i(acc_ready),
    .out_acc_o  (acc),
    .out_neg_o  (acc_neg)
  );

  ecef_ltt_finish #(
    .COORD_WIDTH   (COORD_WIDTH),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_finish (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (acc_valid),
    .in_ready_o (acc_ready),
    .in_acc_i   (acc),
    .in_neg_i   (acc_neg),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_vec_o  (out_vec),
    .out_sat_o  (m_axis_tuser)
  );

  // Pack output coordinates, zero fill to whole bytes
  assign m_axis_tdata = TDW'(out_vec);

`ifndef SYNTHESIS
  localparam logic [COORD_WIDTH-1:0] AMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] AMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // A saturated result has at least one coordinate at a range limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (out_vec[0] == AMAX || out_vec[0] == AMIN ||
       out_vec[1] == AMAX || out_vec[1] == AMIN ||
       out_vec[2] == AMAX || out_vec[2] == AMIN))
    else $error("saturated flag without a clipped coordinate");

  // The input side never stalls while the output side can drain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tready || !m_axis_tvalid) |-> s_axis_tready)
    else $error("input stalled with a draining output");

  // An accepted transaction reaches the output while the output side is not backpressured
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
      ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("accepted transaction did not reach the output");
`endif

endmodule
